/* rtl/ray_triangle_hit_test_macros.svh */
`ifndef RAY_TRIANGLE_HIT_TEST_MACROS_SVH
`define RAY_TRIANGLE_HIT_TEST_MACROS_SVH
// Check that a condition implies a consequence in the same cycle.
`define RTH_ASSERT_IMPL(label, clk, rstn, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond) |-> (prop)) \
        else $error("assertion failed");
// Check that a condition implies a consequence in the following cycle.
`define RTH_ASSERT_NEXT(label, clk, rstn, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> (prop)) \
        else $error("assertion failed");
`endif

/* rtl/rth_pkg.sv */
package rth_pkg;
    localparam int unsigned CFG_IDX_WIDTH = 3;
    localparam int unsigned CFG_DATA_WIDTH = 52;
    localparam int unsigned PROD_WIDTH = 64;
    localparam int unsigned DIST_WIDTH = 32;
    localparam int unsigned FRAC_BITS = 16;
    localparam int unsigned DIV_STEPS = 32;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_ORIGIN_X = 3'd0;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_ORIGIN_Y = 3'd1;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_ORIGIN_Z = 3'd2;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_DIR_X = 3'd3;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_DIR_Y = 3'd4;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_DIR_Z = 3'd5;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_DET_MIN = 3'd6;
    localparam logic [DIST_WIDTH-1:0] DIST_SAT = 32'hFFFF_FFFF;

    typedef struct packed {
        logic                    hit;
        logic [PROD_WIDTH-1:0]   num;
        logic [PROD_WIDTH-1:0]   den;
    } rth_div_req_t;
endpackage

/* rtl/rth_geom.sv */
module rth_geom import rth_pkg::*; #(
    parameter int unsigned COORD_WIDTH = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          adv,
    input  logic                          in_valid,
    input  logic [9*COORD_WIDTH-1:0]      in_verts,
    input  logic [3*COORD_WIDTH-1:0]      origin,
    input  logic [3*COORD_WIDTH-1:0]      dir,
    input  logic [CFG_DATA_WIDTH-1:0]     det_min,
    output logic                          out_valid,
    output rth_div_req_t                  out_req
);
    localparam int unsigned EW = COORD_WIDTH + 1;
    localparam int unsigned NW = 2*EW + 2;

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic signed [EW-1:0] e1_reg [3];
    logic signed [EW-1:0] e2_reg [3];
    logic signed [EW-1:0] ao_reg [3];
    logic signed [EW-1:0] e1b_reg [3];
    logic signed [EW-1:0] e2b_reg [3];
    logic signed [EW-1:0] aob_reg [3];
    logic signed [NW-1:0] n_reg [3];
    logic signed [NW-1:0] dao_reg [3];
    logic signed [PROD_WIDTH-1:0] pt_reg [3];
    logic signed [PROD_WIDTH-1:0] pd_reg [3];
    logic signed [PROD_WIDTH-1:0] pu_reg [3];
    logic signed [PROD_WIDTH-1:0] pv_reg [3];
    logic signed [PROD_WIDTH-1:0] det_reg, nt_reg, nu_reg, nv_reg;

    logic signed [EW-1:0] a_s [3];
    logic signed [EW-1:0] b_s [3];
    logic signed [EW-1:0] c_s [3];
    logic signed [EW-1:0] o_s [3];
    logic signed [EW-1:0] d_s [3];
    logic signed [PROD_WIDTH-1:0] det_s, nt_s, nu_s, nv_s, sum_uv;
    logic hit_s;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            a_s[i] = EW'($signed(in_verts[i*COORD_WIDTH +: COORD_WIDTH]));
            b_s[i] = EW'($signed(in_verts[(3+i)*COORD_WIDTH +: COORD_WIDTH]));
            c_s[i] = EW'($signed(in_verts[(6+i)*COORD_WIDTH +: COORD_WIDTH]));
            o_s[i] = EW'($signed(origin[i*COORD_WIDTH +: COORD_WIDTH]));
            d_s[i] = EW'($signed(dir[i*COORD_WIDTH +: COORD_WIDTH]));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < 3; i++) begin
                e1_reg[i] <= b_s[i] - a_s[i];
                e2_reg[i] <= c_s[i] - a_s[i];
                ao_reg[i] <= o_s[i] - a_s[i];
                e1b_reg[i] <= e1_reg[i];
                e2b_reg[i] <= e2_reg[i];
                aob_reg[i] <= ao_reg[i];
            end
            n_reg[0] <= NW'(e1_reg[1] * e2_reg[2]) - NW'(e1_reg[2] * e2_reg[1]);
            n_reg[1] <= NW'(e1_reg[2] * e2_reg[0]) - NW'(e1_reg[0] * e2_reg[2]);
            n_reg[2] <= NW'(e1_reg[0] * e2_reg[1]) - NW'(e1_reg[1] * e2_reg[0]);
            dao_reg[0] <= NW'(ao_reg[1] * d_s[2]) - NW'(ao_reg[2] * d_s[1]);
            dao_reg[1] <= NW'(ao_reg[2] * d_s[0]) - NW'(ao_reg[0] * d_s[2]);
            dao_reg[2] <= NW'(ao_reg[0] * d_s[1]) - NW'(ao_reg[1] * d_s[0]);
            for (int i = 0; i < 3; i++) begin
                pd_reg[i] <= PROD_WIDTH'(d_s[i] * n_reg[i]);
                pt_reg[i] <= PROD_WIDTH'(aob_reg[i] * n_reg[i]);
                pu_reg[i] <= PROD_WIDTH'(e2b_reg[i] * dao_reg[i]);
                pv_reg[i] <= PROD_WIDTH'(e1b_reg[i] * dao_reg[i]);
            end
            det_reg <= -(pd_reg[0] + pd_reg[1] + pd_reg[2]);
            nt_reg <= pt_reg[0] + pt_reg[1] + pt_reg[2];
            nu_reg <= pu_reg[0] + pu_reg[1] + pu_reg[2];
            nv_reg <= -(pv_reg[0] + pv_reg[1] + pv_reg[2]);
        end
    end

    always_comb begin
        det_s = det_reg;
        nt_s = nt_reg;
        nu_s = nu_reg;
        nv_s = nv_reg;
        sum_uv = nu_s + nv_s;
        hit_s = (det_s > 0) && ($unsigned(det_s) >= PROD_WIDTH'(det_min))
                && !nt_s[PROD_WIDTH-1] && !nu_s[PROD_WIDTH-1]
                && !nv_s[PROD_WIDTH-1] && (sum_uv <= det_s);
    end

    assign out_valid = v4_reg;
    assign out_req.hit = hit_s;
    assign out_req.num = nt_s;
    assign out_req.den = det_s;
endmodule

/* rtl/rth_div.sv */
module rth_div import rth_pkg::*; (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   adv,
    input  logic                   in_valid,
    input  rth_div_req_t           in_req,
    output logic                   out_valid,
    output logic                   out_hit,
    output logic [DIST_WIDTH-1:0]  out_dist
);
    localparam int unsigned RW = PROD_WIDTH + 1;

    logic                   v_reg [DIV_STEPS+1];
    logic                   h_reg [DIV_STEPS+1];
    logic                   sat_reg [DIV_STEPS+1];
    logic [PROD_WIDTH-1:0]  d_reg [DIV_STEPS+1];
    logic [RW-1:0]          r_reg [DIV_STEPS+1];
    logic [PROD_WIDTH-1:0]  n_reg [DIV_STEPS+1];
    logic [DIST_WIDTH-1:0]  q_reg [DIV_STEPS+1];

    logic [PROD_WIDTH+FRAC_BITS-1:0] hi_limit;
    assign hi_limit = {in_req.den, {FRAC_BITS{1'b0}}};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k <= DIV_STEPS; k++) v_reg[k] <= 1'b0;
        end else if (adv) begin
            v_reg[0] <= in_valid;
            for (int k = 1; k <= DIV_STEPS; k++) v_reg[k] <= v_reg[k-1];
        end
    end

    // quotient = (num << 16) / den, 32 bits; remainder starts from num >> 16
    always_ff @(posedge aclk) begin
        if (adv) begin
            h_reg[0] <= in_req.hit;
            sat_reg[0] <= (PROD_WIDTH+FRAC_BITS)'(in_req.num) >= hi_limit;
            d_reg[0] <= in_req.den;
            r_reg[0] <= RW'(in_req.num[PROD_WIDTH-1:FRAC_BITS]);
            n_reg[0] <= in_req.num;
            q_reg[0] <= '0;
            for (int k = 1; k <= DIV_STEPS; k++) begin
                logic [RW-1:0] sh;
                logic          bit_in;
                if (k <= DIV_STEPS - FRAC_BITS)
                    bit_in = n_reg[k-1][DIST_WIDTH - FRAC_BITS - k];
                else
                    bit_in = 1'b0;
                sh = {r_reg[k-1][RW-2:0], bit_in};
                h_reg[k] <= h_reg[k-1];
                sat_reg[k] <= sat_reg[k-1];
                d_reg[k] <= d_reg[k-1];
                n_reg[k] <= n_reg[k-1];
                if (sh >= {1'b0, d_reg[k-1]}) begin
                    r_reg[k] <= sh - {1'b0, d_reg[k-1]};
                    q_reg[k] <= {q_reg[k-1][DIST_WIDTH-2:0], 1'b1};
                end else begin
                    r_reg[k] <= sh;
                    q_reg[k] <= {q_reg[k-1][DIST_WIDTH-2:0], 1'b0};
                end
            end
        end
    end

    assign out_valid = v_reg[DIV_STEPS];
    assign out_hit = h_reg[DIV_STEPS];
    assign out_dist = !h_reg[DIV_STEPS] ? '0 :
                      sat_reg[DIV_STEPS] ? DIST_SAT : q_reg[DIV_STEPS];
endmodule

/* rtl/ray_triangle_hit_test.sv */
// Ray / triangle hit test, front faces only, fixed point.
// Configuration: cfg_we, cfg_index, cfg_data write the ray origin (0..2),
// direction (3..5) and least determinant det_min (6); other indexes are
// ignored. Write only while no item is in flight.
// Input: one triangle per item on s_axis (nine signed Q7.8 coordinates).
// Output: one item per triangle on m_axis: hit flag and distance t in
// unsigned Q16.16 (saturated, 0 on a miss).
// Throughput: one item per cycle while the receiver does not stall. The
// pipe is the 4-stage geometry pipe, the 33-stage restoring divider (a load
// stage, then one quotient bit per stage) and the output register; the first
// of these 38 registers loads at the accepting edge.
// Reset (aresetn low, synchronous) empties the pipe and restores the
// register reset values.
// When the receiver stalls the whole pipe holds; s_axis_tready follows the
// output register, so an item is accepted whenever the output slot drains
// or is empty. No item is lost or repeated.
`include "ray_triangle_hit_test_macros.svh"
module ray_triangle_hit_test import rth_pkg::*; #(
    parameter int unsigned COORD_WIDTH = 16
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_we,
    input  logic [CFG_IDX_WIDTH-1:0]    cfg_index,
    input  logic [CFG_DATA_WIDTH-1:0]   cfg_data,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    // vert_a_x, vert_a_y, vert_a_z, vert_b_x .. vert_c_z
    input  logic [((9*COORD_WIDTH+7)/8)*8-1:0] s_axis_tdata,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // hit, hit_distance, zero fill
    output logic [39:0]                 m_axis_tdata
);
    logic [COORD_WIDTH-1:0] org_reg [3];
    logic [COORD_WIDTH-1:0] dir_reg [3];
    logic [CFG_DATA_WIDTH-1:0] det_min_reg;
    logic [3*COORD_WIDTH-1:0] org_flat, dir_flat;
    logic adv, g_valid, d_valid, d_hit;
    rth_div_req_t g_req;
    logic [DIST_WIDTH-1:0] d_dist;
    logic out_v_reg;
    logic out_hit_reg;
    logic [DIST_WIDTH-1:0] out_dist_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 3; i++) begin
                org_reg[i] <= '0;
                dir_reg[i] <= '0;
            end
            det_min_reg <= CFG_DATA_WIDTH'(17);
        end else if (cfg_we) begin
            case (cfg_index)
                REG_ORIGIN_X: org_reg[0] <= cfg_data[COORD_WIDTH-1:0];
                REG_ORIGIN_Y: org_reg[1] <= cfg_data[COORD_WIDTH-1:0];
                REG_ORIGIN_Z: org_reg[2] <= cfg_data[COORD_WIDTH-1:0];
                REG_DIR_X:    dir_reg[0] <= cfg_data[COORD_WIDTH-1:0];
                REG_DIR_Y:    dir_reg[1] <= cfg_data[COORD_WIDTH-1:0];
                REG_DIR_Z:    dir_reg[2] <= cfg_data[COORD_WIDTH-1:0];
                REG_DET_MIN:  det_min_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    assign org_flat = {org_reg[2], org_reg[1], org_reg[0]};
    assign dir_flat = {dir_reg[2], dir_reg[1], dir_reg[0]};
    assign adv = !out_v_reg || m_axis_tready;
    assign s_axis_tready = adv;

    rth_geom #(.COORD_WIDTH(COORD_WIDTH)) u_geom (
        .aclk(aclk), .aresetn(aresetn), .adv(adv),
        .in_valid(s_axis_tvalid),
        .in_verts(s_axis_tdata[9*COORD_WIDTH-1:0]),
        .origin(org_flat), .dir(dir_flat), .det_min(det_min_reg),
        .out_valid(g_valid), .out_req(g_req)
    );

    rth_div u_div (
        .aclk(aclk), .aresetn(aresetn), .adv(adv),
        .in_valid(g_valid), .in_req(g_req),
        .out_valid(d_valid), .out_hit(d_hit), .out_dist(d_dist)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_v_reg <= 1'b0;
        end else if (adv) begin
            out_v_reg <= d_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            out_hit_reg <= d_hit;
            out_dist_reg <= d_dist;
        end
    end

    assign m_axis_tvalid = out_v_reg;
    assign m_axis_tdata = {7'd0, out_dist_reg, out_hit_reg};

    `RTH_ASSERT_NEXT(a_hold, aclk, aresetn, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata))
    `RTH_ASSERT_IMPL(a_miss_zero, aclk, aresetn, m_axis_tvalid && !m_axis_tdata[0],
        m_axis_tdata[32:1] == '0)
    `RTH_ASSERT_IMPL(a_ready, aclk, aresetn, !m_axis_tvalid, s_axis_tready)
endmodule

/* verif/tb_ray_triangle_hit_test.sv */
module tb_ray_triangle_hit_test;
    import rth_pkg::*;

    localparam int unsigned CW = 16;
    localparam int unsigned IN_W = ((9 * CW + 7) / 8) * 8;
    localparam logic [CFG_IDX_WIDTH-1:0] REG_UNUSED = 3'd7;
    localparam longint DET_MIN_MAX = (64'd1 << 52) - 1;
    localparam int CYCLE_LIMIT = 600000;

    typedef logic signed [CW-1:0] coord_t;
    typedef coord_t tri_t [9];

    typedef struct {
        logic        hit;
        logic [31:0] hit_distance;
    } hit_result_t;

    logic                      aclk = 1'b0;
    logic                      aresetn = 1'b0;
    logic                      cfg_we = 1'b0;
    logic [CFG_IDX_WIDTH-1:0]  cfg_index = '0;
    logic [CFG_DATA_WIDTH-1:0] cfg_data = '0;
    logic                      s_axis_tvalid = 1'b0;
    logic                      s_axis_tready;
    logic [IN_W-1:0]           s_axis_tdata = '0;
    logic                      m_axis_tvalid;
    logic                      m_axis_tready = 1'b0;
    logic [39:0]               m_axis_tdata;

    coord_t ray_origin [3];
    coord_t ray_dir [3];
    longint ray_det_min;

    hit_result_t expected_hits [$];
    int     mismatches = 0;
    int     cycles = 0;
    bit     no_idle = 1'b0;
    int     rx_stall = 0;

    ray_triangle_hit_test #(.COORD_WIDTH(CW)) i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    initial begin
        forever #10 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic hit_result_t predict_hit(tri_t v);
        hit_result_t res;
        longint a[3], e1[3], e2[3], ao[3], d[3], n[3], dao[3];
        longint det, num_t, num_u, num_v, q;
        logic [127:0] wide;
        for (int i = 0; i < 3; i++) begin
            a[i]  = v[i];
            e1[i] = longint'(v[3 + i]) - a[i];
            e2[i] = longint'(v[6 + i]) - a[i];
            ao[i] = longint'(ray_origin[i]) - a[i];
            d[i]  = ray_dir[i];
        end
        n[0] = e1[1] * e2[2] - e1[2] * e2[1];
        n[1] = e1[2] * e2[0] - e1[0] * e2[2];
        n[2] = e1[0] * e2[1] - e1[1] * e2[0];
        dao[0] = ao[1] * d[2] - ao[2] * d[1];
        dao[1] = ao[2] * d[0] - ao[0] * d[2];
        dao[2] = ao[0] * d[1] - ao[1] * d[0];
        det   = -(d[0] * n[0] + d[1] * n[1] + d[2] * n[2]);
        num_t = ao[0] * n[0] + ao[1] * n[1] + ao[2] * n[2];
        num_u = e2[0] * dao[0] + e2[1] * dao[1] + e2[2] * dao[2];
        num_v = -(e1[0] * dao[0] + e1[1] * dao[1] + e1[2] * dao[2]);
        res.hit = det > 0 && det >= ray_det_min && num_t >= 0 && num_u >= 0
                  && num_v >= 0 && num_u + num_v <= det;
        res.hit_distance = '0;
        if (res.hit) begin
            q = num_t / det;
            if (q >= 65536) begin
                res.hit_distance = DIST_SAT;
            end else begin
                wide = {64'd0, num_t} << FRAC_BITS;
                wide = wide / {64'd0, det};
                res.hit_distance = wide[31:0];
            end
        end
        return res;
    endfunction

    task automatic write_reg(logic [CFG_IDX_WIDTH-1:0] idx, logic [CFG_DATA_WIDTH-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            REG_ORIGIN_X, REG_ORIGIN_Y, REG_ORIGIN_Z: ray_origin[idx] = val[CW-1:0];
            REG_DIR_X, REG_DIR_Y, REG_DIR_Z: ray_dir[idx - REG_DIR_X] = val[CW-1:0];
            REG_DET_MIN: ray_det_min = val;
            default: ;
        endcase
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (expected_hits.size() != 0) @(posedge aclk);
        repeat (50) @(posedge aclk);
    endtask

    task automatic set_ray(int ox, int oy, int oz, int dx, int dy, int dz, longint dmin);
        drain();
        write_reg(REG_ORIGIN_X, CFG_DATA_WIDTH'(ox));
        write_reg(REG_ORIGIN_Y, CFG_DATA_WIDTH'(oy));
        write_reg(REG_ORIGIN_Z, CFG_DATA_WIDTH'(oz));
        write_reg(REG_DIR_X, CFG_DATA_WIDTH'(dx));
        write_reg(REG_DIR_Y, CFG_DATA_WIDTH'(dy));
        write_reg(REG_DIR_Z, CFG_DATA_WIDTH'(dz));
        write_reg(REG_DET_MIN, CFG_DATA_WIDTH'(dmin));
    endtask

    task automatic send_tri(tri_t v);
        int gap;
        logic [IN_W-1:0] word;
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        word = '0;
        for (int i = 0; i < 9; i++) word[CW*i +: CW] = v[i];
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= word;
        do @(posedge aclk); while (!s_axis_tready);
        expected_hits.push_back(predict_hit(v));
    endtask

    function automatic coord_t clamp(longint x);
        if (x > 32767) return 16'sd32767;
        if (x < -32768) return -16'sd32768;
        return coord_t'(x);
    endfunction

    function automatic tri_t noise_tri();
        tri_t v;
        for (int i = 0; i < 9; i++) v[i] = coord_t'($urandom);
        return v;
    endfunction

    // place a triangle around a point on the ray; about half face the ray
    function automatic tri_t aimed_tri();
        tri_t v;
        longint s, p, r;
        int pick;
        s = $urandom_range(0, 4096);
        pick = $urandom_range(0, 9);
        r = pick < 4 ? 64 : (pick < 8 ? 1024 : 8192);
        for (int k = 0; k < 3; k++) begin
            p = longint'(ray_origin[k]) + ((longint'(ray_dir[k]) * s) >>> 8);
            for (int j = 0; j < 3; j++)
                v[3 * j + k] = clamp(p + longint'($urandom_range(0, 2 * r)) - r);
        end
        return v;
    endfunction

    task automatic test_reset_values();
        tri_t v;
        for (int i = 0; i < 6; i++) send_tri(aimed_tri());
        for (int i = 0; i < 9; i++) v[i] = coord_t'(100 * (i % 3));
        send_tri(v);
    endtask

    task automatic test_directed();
        tri_t v;
        // unit ray along +z from below a triangle in the z = 0 plane
        set_ray(0, 0, -2560, 0, 0, 256, 17);
        v = '{-512, -512, 0, 512, -512, 0, 0, 512, 0};
        send_tri(v);
        v = '{-512, -512, 0, 0, 512, 0, 512, -512, 0};
        send_tri(v);
        v = '{256, 256, 0, 512, 256, 0, 256, 512, 0};
        send_tri(v);
        v = '{-512, -512, -5120, 512, -512, -5120, 0, 512, -5120};
        send_tri(v);
        // edge through the ray
        v = '{0, 0, 0, 512, 0, 0, 0, 512, 0};
        send_tri(v);
        // plane parallel to the ray: zero determinant
        set_ray(0, 0, 0, 0, 0, 256, 0);
        v = '{0, -512, 0, 0, 512, 0, 0, 0, 512};
        send_tri(v);
        v = '{0, 0, 0, 0, 0, 0, 0, 0, 0};
        send_tri(v);
        // far triangle with tiny direction: large distance
        set_ray(-32768, 0, 0, 1, 0, 0, 0);
        v = '{32767, -4096, -4096, 32767, -4096, 4096, 32767, 4096, 0};
        send_tri(v);
        v = '{32767, -4096, -4096, 32767, 4096, 0, 32767, -4096, 4096};
        send_tri(v);
        // field extremes
        set_ray(32767, -32768, 32767, -32768, 32767, -32768, 0);
        for (int i = 0; i < 9; i++) v[i] = -16'sd32768;
        send_tri(v);
        for (int i = 0; i < 9; i++) v[i] = 16'sd32767;
        send_tri(v);
        v = '{-32768, 32767, -32768, 32767, -32768, 32767, -32768, -32768, 32767};
        send_tri(v);
        v = '{32767, 32767, -32768, -32768, 32767, 32767, 32767, -32768, 32767};
        send_tri(v);
        // highest threshold rejects everything
        set_ray(0, 0, -2560, 0, 0, 256, DET_MIN_MAX);
        v = '{-512, -512, 0, 512, -512, 0, 0, 512, 0};
        send_tri(v);
        // unknown register index leaves the ray as it is
        drain();
        write_reg(REG_UNUSED, '1);
        write_reg(REG_DET_MIN, 0);
        send_tri(v);
        send_tri(aimed_tri());
    endtask

    task automatic test_random_rays();
        int phases;
        phases = 9;
        for (int ph = 0; ph < phases; ph++) begin
            case (ph)
                0: set_ray(0, 0, 0, 256, 0, 0, 17);
                1: set_ray(-32768, -32768, -32768, 32767, 32767, 32767, 0);
                2: set_ray(32767, 32767, 32767, -32768, -32768, -32768, 1);
                3: set_ray(0, 0, 0, 1, -1, 1, 0);
                default: set_ray($urandom_range(0, 8192) - 4096, $urandom_range(0, 8192) - 4096,
                                 $urandom_range(0, 8192) - 4096, $urandom_range(0, 1024) - 512,
                                 $urandom_range(0, 1024) - 512, $urandom_range(0, 1024) - 512,
                                 ph == 8 ? longint'({$urandom, $urandom}) & DET_MIN_MAX
                                         : longint'($urandom_range(0, 4096)));
            endcase
            no_idle = (ph % 3 == 1);
            for (int i = 0; i < 150; i++)
                send_tri($urandom_range(0, 9) < 8 ? aimed_tri() : noise_tri());
        end
        no_idle = 1'b0;
    endtask

    always @(posedge aclk) begin
        if (!aresetn || no_idle) begin
            m_axis_tready <= 1'b1;
        end else if (rx_stall > 0) begin
            rx_stall <= rx_stall - 1;
            m_axis_tready <= 1'b0;
        end else begin
            rx_stall <= pick_gap();
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        hit_result_t exp_res;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (expected_hits.size() == 0) begin
                $error("unexpected item: tdata %h", m_axis_tdata);
                mismatches++;
            end else begin
                exp_res = expected_hits.pop_front();
                if (m_axis_tdata[0] !== exp_res.hit) begin
                    $error("hit: expected %0d, actual %0d", exp_res.hit, m_axis_tdata[0]);
                    mismatches++;
                end
                if (m_axis_tdata[32:1] !== exp_res.hit_distance) begin
                    $error("hit_distance: expected %h, actual %h", exp_res.hit_distance,
                           m_axis_tdata[32:1]);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        for (int i = 0; i < 3; i++) begin
            ray_origin[i] = '0;
            ray_dir[i] = '0;
        end
        ray_det_min = 17;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_reset_values();
        test_directed();
        test_random_rays();
        drain();
        if (expected_hits.size() != 0) mismatches++;
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end
endmodule

/* filelist.f */
+incdir+rtl
rtl/rth_pkg.sv
rtl/rth_geom.sv
rtl/rth_div.sv
rtl/ray_triangle_hit_test.sv
verif/tb_ray_triangle_hit_test.sv
